FILE: design/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, codes and helpers for the tile tray conveyor sequencer.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CMD_WIDTH       = 3;
    localparam int CNT_WIDTH       = 3;
    localparam int LIMIT_WIDTH     = 3;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [LIMIT_WIDTH-1:0] DEAL_LIMIT_RST = 3'd3;
    localparam logic [LIMIT_WIDTH-1:0] JUMP_LIMIT_RST = 3'd4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEAL_ROUND_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_JUMP_STEP_LIMIT  = 1'b1;

    localparam logic [1:0] PH_INIT   = 2'd0;
    localparam logic [1:0] PH_DEAL   = 2'd1;
    localparam logic [1:0] PH_JUMP   = 2'd2;
    localparam logic [1:0] PH_NORMAL = 2'd3;

    localparam logic [1:0] DS_WAIT_FIRST  = 2'd0;
    localparam logic [1:0] DS_TRAY_DOWN   = 2'd1;
    localparam logic [1:0] DS_WAIT_SECOND = 2'd2;
    localparam logic [1:0] DS_TRAY_UP     = 2'd3;

    localparam logic [1:0] JS_START       = 2'd0;
    localparam logic [1:0] JS_WAIT_TWO    = 2'd1;
    localparam logic [1:0] JS_NEXT_SINGLE = 2'd2;
    localparam logic [1:0] JS_WAIT_SINGLE = 2'd3;

    localparam logic [1:0] NS_WAIT_TAKE = 2'd0;
    localparam logic [1:0] NS_TRAY_DOWN = 2'd1;
    localparam logic [1:0] NS_SEND_ONE  = 2'd2;
    localparam logic [1:0] NS_TRAY_UP   = 2'd3;

    localparam logic [CMD_WIDTH-1:0] CONV_NONE         = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CONV_START_BOTH   = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CONV_STOP_BOTH    = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CONV_START_SINGLE = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CONV_STOP_SINGLE  = 3'd4;

    localparam logic [CMD_WIDTH-1:0] TRAY_NONE      = 3'd0;
    localparam logic [CMD_WIDTH-1:0] TRAY_LOWER     = 3'd1;
    localparam logic [CMD_WIDTH-1:0] TRAY_RAISE     = 3'd2;
    localparam logic [CMD_WIDTH-1:0] TRAY_RAISE_TWO = 3'd3;
    localparam logic [CMD_WIDTH-1:0] TRAY_RAISE_ONE = 3'd4;

    localparam logic [CNT_WIDTH-1:0] CNT_MAX = 3'd7;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] deal_round_limit;
        logic [LIMIT_WIDTH-1:0] jump_step_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           phase;
        logic [1:0]           deal_sub;
        logic [1:0]           jump_sub;
        logic [1:0]           normal_sub;
        logic [CNT_WIDTH-1:0] round_count;
        logic [CNT_WIDTH-1:0] step_count;
    } ctrl_t;

    typedef struct packed {
        logic                 init_pulse;
        logic [CMD_WIDTH-1:0] conveyor_cmd;
        logic [CMD_WIDTH-1:0] tray_cmd;
        logic [1:0]           main_phase;
        logic [1:0]           sub_phase;
        logic [CNT_WIDTH-1:0] rounds_done;
        logic [CNT_WIDTH-1:0] jump_count;
    } result_t;

    function automatic logic [CNT_WIDTH-1:0] inc_sat7(input logic [CNT_WIDTH-1:0] v);
        inc_sat7 = (v == CNT_MAX) ? CNT_MAX : v + CNT_WIDTH'(1);
    endfunction

endpackage

FILE: design/tts_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_sample_if
// Sensor sample channel: two tile counts and the tray completion flags.
// ----------------------------------------------------------------------------
interface tts_sample_if #(
    parameter int COUNT_WIDTH = tts_pkg::COUNT_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] ir_count_left;
    logic [COUNT_WIDTH-1:0] ir_count_right;
    logic                   tray_down_done;
    logic                   tray_up_done;

    modport source (
        output valid, ir_count_left, ir_count_right, tray_down_done, tray_up_done,
        input  ready
    );

    modport sink (
        input  valid, ir_count_left, ir_count_right, tray_down_done, tray_up_done,
        output ready
    );
endinterface

FILE: design/tts_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_result_if
// Result channel: commands and sequencer status for one tick.
// ----------------------------------------------------------------------------
interface tts_result_if;
    logic                            valid;
    logic                            ready;
    logic                            init_pulse;
    logic [tts_pkg::CMD_WIDTH-1:0]   conveyor_cmd;
    logic [tts_pkg::CMD_WIDTH-1:0]   tray_cmd;
    logic [1:0]                      main_phase;
    logic [1:0]                      sub_phase;
    logic [tts_pkg::CNT_WIDTH-1:0]   rounds_done;
    logic [tts_pkg::CNT_WIDTH-1:0]   jump_count;

    modport source (
        output valid, init_pulse, conveyor_cmd, tray_cmd, main_phase, sub_phase,
               rounds_done, jump_count,
        input  ready
    );

    modport sink (
        input  valid, init_pulse, conveyor_cmd, tray_cmd, main_phase, sub_phase,
               rounds_done, jump_count,
        output ready
    );
endinterface

FILE: design/tts_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_cfg
// Configuration registers: deal round limit and jump step limit.
// ----------------------------------------------------------------------------
module tts_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tts_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tts_pkg::LIMIT_WIDTH-1:0]     cfg_data,
    output tts_pkg::cfg_t                       cfg
);

    tts_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deal_round_limit <= tts_pkg::DEAL_LIMIT_RST;
            cfg_reg.jump_step_limit  <= tts_pkg::JUMP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tts_pkg::REG_DEAL_ROUND_LIMIT: cfg_reg.deal_round_limit <= cfg_data;
                tts_pkg::REG_JUMP_STEP_LIMIT:  cfg_reg.jump_step_limit  <= cfg_data;
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/tts_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_step
// One sequencer tick: next control state, baseline load and result item.
// ----------------------------------------------------------------------------
module tts_step #(
    parameter int COUNT_WIDTH = tts_pkg::COUNT_WIDTH_DEF
) (
    input  tts_pkg::cfg_t           cfg,
    input  tts_pkg::ctrl_t          ctrl,
    input  logic [COUNT_WIDTH-1:0]  base_left,
    input  logic [COUNT_WIDTH-1:0]  base_right,
    input  logic [COUNT_WIDTH-1:0]  left,
    input  logic [COUNT_WIDTH-1:0]  right,
    input  logic                    down_done,
    input  logic                    up_done,
    output tts_pkg::ctrl_t          ctrl_next,
    output logic                    base_load,
    output tts_pkg::result_t        result
);

    localparam int SW = COUNT_WIDTH + 2;

    logic [SW-1:0]                 left_w;
    logic [SW-1:0]                 right_w;
    logic [SW-1:0]                 bl_w;
    logic [SW-1:0]                 br_w;
    logic [SW-1:0]                 now_sum;
    logic [SW-1:0]                 base_sum;
    logic [tts_pkg::CNT_WIDTH-1:0] round_inc;
    logic [tts_pkg::CNT_WIDTH-1:0] step_inc;
    logic [tts_pkg::CMD_WIDTH-1:0] conv;
    logic [tts_pkg::CMD_WIDTH-1:0] tray;
    logic                          init;
    logic [1:0]                    sub_out;

    assign left_w    = SW'(left);
    assign right_w   = SW'(right);
    assign bl_w      = SW'(base_left);
    assign br_w      = SW'(base_right);
    assign now_sum   = left_w + right_w;
    assign base_sum  = bl_w + br_w;
    assign round_inc = tts_pkg::inc_sat7(ctrl.round_count);
    assign step_inc  = tts_pkg::inc_sat7(ctrl.step_count);

    always_comb
    begin
        ctrl_next = ctrl;
        base_load = 1'b0;
        init      = 1'b0;
        conv      = tts_pkg::CONV_NONE;
        tray      = tts_pkg::TRAY_NONE;

        unique case (ctrl.phase)
            tts_pkg::PH_INIT:
            begin
                init            = 1'b1;
                ctrl_next.phase = tts_pkg::PH_DEAL;
            end
            tts_pkg::PH_DEAL:
            begin
                unique case (ctrl.deal_sub)
                    tts_pkg::DS_WAIT_FIRST:
                    begin
                        if (left_w > bl_w && right_w > br_w)
                        begin
                            conv               = tts_pkg::CONV_STOP_BOTH;
                            tray               = tts_pkg::TRAY_LOWER;
                            ctrl_next.deal_sub = tts_pkg::DS_TRAY_DOWN;
                        end
                    end
                    tts_pkg::DS_TRAY_DOWN:
                    begin
                        if (down_done)
                        begin
                            conv               = tts_pkg::CONV_START_BOTH;
                            ctrl_next.deal_sub = tts_pkg::DS_WAIT_SECOND;
                        end
                    end
                    tts_pkg::DS_WAIT_SECOND:
                    begin
                        if (left_w > bl_w + SW'(1) && right_w > br_w + SW'(1))
                        begin
                            conv               = tts_pkg::CONV_STOP_BOTH;
                            tray               = tts_pkg::TRAY_RAISE;
                            ctrl_next.deal_sub = tts_pkg::DS_TRAY_UP;
                        end
                    end
                    default:
                    begin
                        if (up_done)
                        begin
                            base_load             = 1'b1;
                            ctrl_next.round_count = round_inc;
                            if (round_inc >= cfg.deal_round_limit)
                                ctrl_next.phase = tts_pkg::PH_JUMP;
                            else
                                ctrl_next.deal_sub = tts_pkg::DS_WAIT_FIRST;
                        end
                    end
                endcase
            end
            tts_pkg::PH_JUMP:
            begin
                unique case (ctrl.jump_sub)
                    tts_pkg::JS_START:
                    begin
                        tray               = tts_pkg::TRAY_RAISE_TWO;
                        ctrl_next.jump_sub = tts_pkg::JS_WAIT_TWO;
                    end
                    tts_pkg::JS_WAIT_TWO:
                    begin
                        if (now_sum >= base_sum + SW'(2))
                        begin
                            ctrl_next.step_count = tts_pkg::CNT_WIDTH'(1);
                            ctrl_next.jump_sub   = tts_pkg::JS_NEXT_SINGLE;
                        end
                    end
                    tts_pkg::JS_NEXT_SINGLE:
                    begin
                        tray               = tts_pkg::TRAY_RAISE_ONE;
                        ctrl_next.jump_sub = tts_pkg::JS_WAIT_SINGLE;
                    end
                    default:
                    begin
                        if (now_sum >= base_sum + SW'(ctrl.step_count) + SW'(2))
                        begin
                            ctrl_next.step_count = step_inc;
                            if (step_inc >= cfg.jump_step_limit)
                            begin
                                ctrl_next.phase      = tts_pkg::PH_NORMAL;
                                ctrl_next.normal_sub = tts_pkg::NS_WAIT_TAKE;
                                base_load            = 1'b1;
                            end
                            else
                            begin
                                ctrl_next.jump_sub = tts_pkg::JS_NEXT_SINGLE;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                unique case (ctrl.normal_sub)
                    tts_pkg::NS_WAIT_TAKE:
                    begin
                        if (now_sum > base_sum)
                        begin
                            tray                 = tts_pkg::TRAY_LOWER;
                            ctrl_next.normal_sub = tts_pkg::NS_TRAY_DOWN;
                        end
                    end
                    tts_pkg::NS_TRAY_DOWN:
                    begin
                        if (down_done)
                        begin
                            conv                 = tts_pkg::CONV_START_SINGLE;
                            ctrl_next.normal_sub = tts_pkg::NS_SEND_ONE;
                        end
                    end
                    tts_pkg::NS_SEND_ONE:
                    begin
                        if (now_sum > base_sum + SW'(1))
                        begin
                            conv                 = tts_pkg::CONV_STOP_SINGLE;
                            tray                 = tts_pkg::TRAY_RAISE;
                            ctrl_next.normal_sub = tts_pkg::NS_TRAY_UP;
                        end
                    end
                    default:
                    begin
                        if (up_done)
                        begin
                            base_load            = 1'b1;
                            ctrl_next.normal_sub = tts_pkg::NS_WAIT_TAKE;
                        end
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        unique case (ctrl_next.phase)
            tts_pkg::PH_INIT:   sub_out = 2'd0;
            tts_pkg::PH_DEAL:   sub_out = ctrl_next.deal_sub;
            tts_pkg::PH_JUMP:   sub_out = ctrl_next.jump_sub;
            default:            sub_out = ctrl_next.normal_sub;
        endcase
    end

    assign result.init_pulse   = init;
    assign result.conveyor_cmd = conv;
    assign result.tray_cmd     = tray;
    assign result.main_phase   = ctrl_next.phase;
    assign result.sub_phase    = sub_out;
    assign result.rounds_done  = ctrl_next.round_count;
    assign result.jump_count   = ctrl_next.step_count;

endmodule

FILE: design/tile_tray_conveyor_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_tray_conveyor_sequencer
// Init, deal, jump and normal draw sequencer for the tile tray and conveyors.
// ----------------------------------------------------------------------------
// Takes one sensor sample per clock while results are taken and returns one
// result per sample, in order. A sample is held in an input register and the
// sequencer tick is combinational from that register into the result
// register. A result waiting on the output does not stop the next request
// being taken into an empty input register, but with both registers full
// the input stalls until the result is taken. Limits are to be written by
// the user through cfg_we/cfg_index/cfg_data while the block is idle; the
// block itself does not enforce this.
module tile_tray_conveyor_sequencer #(
    parameter int COUNT_WIDTH = tts_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tts_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tts_pkg::LIMIT_WIDTH-1:0]     cfg_data,
    tts_sample_if.sink                          sample,
    tts_result_if.source                        result
);

    tts_pkg::cfg_t          cfg;
    tts_pkg::ctrl_t         ctrl_reg;
    tts_pkg::ctrl_t         ctrl_next;
    tts_pkg::result_t       res_next;
    tts_pkg::result_t       res_reg;
    logic                   base_load;
    logic [COUNT_WIDTH-1:0] base_left_reg;
    logic [COUNT_WIDTH-1:0] base_right_reg;

    logic                   in_valid_reg;
    logic [COUNT_WIDTH-1:0] in_left_reg;
    logic [COUNT_WIDTH-1:0] in_right_reg;
    logic                   in_down_reg;
    logic                   in_up_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   in_take;

    tts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tts_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cfg        (cfg),
        .ctrl       (ctrl_reg),
        .base_left  (base_left_reg),
        .base_right (base_right_reg),
        .left       (in_left_reg),
        .right      (in_right_reg),
        .down_done  (in_down_reg),
        .up_done    (in_up_reg),
        .ctrl_next  (ctrl_next),
        .base_load  (base_load),
        .result     (res_next)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign in_take      = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_left_reg  <= sample.ir_count_left;
            in_right_reg <= sample.ir_count_right;
            in_down_reg  <= sample.tray_down_done;
            in_up_reg    <= sample.tray_up_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase       <= tts_pkg::PH_INIT;
            ctrl_reg.deal_sub    <= tts_pkg::DS_WAIT_FIRST;
            ctrl_reg.jump_sub    <= tts_pkg::JS_START;
            ctrl_reg.normal_sub  <= tts_pkg::NS_WAIT_TAKE;
            ctrl_reg.round_count <= '0;
            ctrl_reg.step_count  <= '0;
            base_left_reg        <= '0;
            base_right_reg       <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_next;
            if (base_load)
            begin
                base_left_reg  <= in_left_reg;
                base_right_reg <= in_right_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.init_pulse   = res_reg.init_pulse;
    assign result.conveyor_cmd = res_reg.conveyor_cmd;
    assign result.tray_cmd     = res_reg.tray_cmd;
    assign result.main_phase   = res_reg.main_phase;
    assign result.sub_phase    = res_reg.sub_phase;
    assign result.rounds_done  = res_reg.rounds_done;
    assign result.jump_count   = res_reg.jump_count;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tile tray conveyor sequencer.
// ----------------------------------------------------------------------------
// A short list of hand-written sensor ticks walks the init tick and the first
// two deal rounds, some with their results written out by hand. Random ticks
// then take the sequencer through the remaining deal rounds, the jump phase
// and a long stretch of normal draw. Most random ticks are built around the
// current baselines so that the sequence keeps moving; the rest are noise.
// The remaining results are checked against an in-bench copy of the sequencer. The
// limits are rewritten between phases while the block is idle.
module testbench;

    import tts_pkg::*;

    localparam int CW            = COUNT_WIDTH_DEF;
    localparam int COUNT_TOP     = (1 << CW) - 1;
    localparam int PLAN_ROWS     = 16;
    localparam int ITEM_TOTAL    = 1150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_CAP    = 100;

    typedef struct packed {
        logic [CW-1:0] left;
        logic [CW-1:0] right;
        logic          down;
        logic          up;
        logic          typed;
        result_t       res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [LIMIT_WIDTH-1:0]     cfg_data;

    tts_sample_if #(.COUNT_WIDTH(CW)) sample_ch ();
    tts_result_if                     result_ch ();

    tile_tray_conveyor_sequencer #(
        .COUNT_WIDTH(CW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // sequencer copy
    logic [1:0]             seq_phase      = PH_INIT;
    logic [1:0]             seq_deal_sub   = DS_WAIT_FIRST;
    logic [1:0]             seq_jump_sub   = JS_START;
    logic [1:0]             seq_normal_sub = NS_WAIT_TAKE;
    logic [CW-1:0]          seq_base_left  = '0;
    logic [CW-1:0]          seq_base_right = '0;
    logic [CNT_WIDTH-1:0]   seq_rounds     = '0;
    logic [CNT_WIDTH-1:0]   seq_steps      = '0;
    logic [LIMIT_WIDTH-1:0] lim_deal       = DEAL_LIMIT_RST;
    logic [LIMIT_WIDTH-1:0] lim_jump       = JUMP_LIMIT_RST;

    result_t   expected_ticks[$];
    stim_row_t plan [PLAN_ROWS];
    int        errors       = 0;
    int        results_seen = 0;
    int        items_sent   = 0;
    int        calm_items   = 0;
    int        cycles       = 0;

    function automatic result_t advance_sequencer(input logic [CW-1:0] left,
                                                  input logic [CW-1:0] right,
                                                  input logic down,
                                                  input logic up);
        result_t     res;
        int unsigned l;
        int unsigned r;
        int unsigned bl;
        int unsigned br;
        int unsigned now_sum;
        int unsigned base_sum;
        l        = 32'(left);
        r        = 32'(right);
        bl       = 32'(seq_base_left);
        br       = 32'(seq_base_right);
        now_sum  = l + r;
        base_sum = bl + br;
        res      = '0;
        case (seq_phase)
            PH_INIT:
            begin
                res.init_pulse = 1'b1;
                seq_phase      = PH_DEAL;
            end
            PH_DEAL:
            begin
                case (seq_deal_sub)
                    DS_WAIT_FIRST:
                    begin
                        if (l > bl && r > br)
                        begin
                            res.conveyor_cmd = CONV_STOP_BOTH;
                            res.tray_cmd     = TRAY_LOWER;
                            seq_deal_sub     = DS_TRAY_DOWN;
                        end
                    end
                    DS_TRAY_DOWN:
                    begin
                        if (down)
                        begin
                            res.conveyor_cmd = CONV_START_BOTH;
                            seq_deal_sub     = DS_WAIT_SECOND;
                        end
                    end
                    DS_WAIT_SECOND:
                    begin
                        if (l > bl + 1 && r > br + 1)
                        begin
                            res.conveyor_cmd = CONV_STOP_BOTH;
                            res.tray_cmd     = TRAY_RAISE;
                            seq_deal_sub     = DS_TRAY_UP;
                        end
                    end
                    default:
                    begin
                        if (up)
                        begin
                            seq_base_left  = left;
                            seq_base_right = right;
                            seq_rounds     = (seq_rounds == CNT_MAX) ? CNT_MAX
                                                                     : seq_rounds + 3'd1;
                            if (seq_rounds >= lim_deal)
                                seq_phase = PH_JUMP;
                            else
                                seq_deal_sub = DS_WAIT_FIRST;
                        end
                    end
                endcase
            end
            PH_JUMP:
            begin
                case (seq_jump_sub)
                    JS_START:
                    begin
                        res.tray_cmd = TRAY_RAISE_TWO;
                        seq_jump_sub = JS_WAIT_TWO;
                    end
                    JS_WAIT_TWO:
                    begin
                        if (now_sum >= base_sum + 2)
                        begin
                            seq_steps    = 3'd1;
                            seq_jump_sub = JS_NEXT_SINGLE;
                        end
                    end
                    JS_NEXT_SINGLE:
                    begin
                        res.tray_cmd = TRAY_RAISE_ONE;
                        seq_jump_sub = JS_WAIT_SINGLE;
                    end
                    default:
                    begin
                        if (now_sum >= base_sum + 32'(seq_steps) + 2)
                        begin
                            seq_steps = (seq_steps == CNT_MAX) ? CNT_MAX : seq_steps + 3'd1;
                            if (seq_steps >= lim_jump)
                            begin
                                seq_phase      = PH_NORMAL;
                                seq_normal_sub = NS_WAIT_TAKE;
                                seq_base_left  = left;
                                seq_base_right = right;
                            end
                            else
                                seq_jump_sub = JS_NEXT_SINGLE;
                        end
                    end
                endcase
            end
            default:
            begin
                case (seq_normal_sub)
                    NS_WAIT_TAKE:
                    begin
                        if (now_sum > base_sum)
                        begin
                            res.tray_cmd   = TRAY_LOWER;
                            seq_normal_sub = NS_TRAY_DOWN;
                        end
                    end
                    NS_TRAY_DOWN:
                    begin
                        if (down)
                        begin
                            res.conveyor_cmd = CONV_START_SINGLE;
                            seq_normal_sub   = NS_SEND_ONE;
                        end
                    end
                    NS_SEND_ONE:
                    begin
                        if (now_sum > base_sum + 1)
                        begin
                            res.conveyor_cmd = CONV_STOP_SINGLE;
                            res.tray_cmd     = TRAY_RAISE;
                            seq_normal_sub   = NS_TRAY_UP;
                        end
                    end
                    default:
                    begin
                        if (up)
                        begin
                            seq_base_left  = left;
                            seq_base_right = right;
                            seq_normal_sub = NS_WAIT_TAKE;
                        end
                    end
                endcase
            end
        endcase
        res.main_phase = seq_phase;
        case (seq_phase)
            PH_DEAL:   res.sub_phase = seq_deal_sub;
            PH_JUMP:   res.sub_phase = seq_jump_sub;
            PH_NORMAL: res.sub_phase = seq_normal_sub;
            default:   res.sub_phase = 2'd0;
        endcase
        res.rounds_done = seq_rounds;
        res.jump_count  = seq_steps;
        return res;
    endfunction

    // holds the request until taken, records its expectation, then sometimes idles a while
    task automatic offer_sample(input logic [CW-1:0] left, input logic [CW-1:0] right,
                                input logic down, input logic up,
                                input logic typed, input result_t typed_res);
        result_t predicted;
        int      gap;
        int      r;
        sample_ch.valid          <= 1'b1;
        sample_ch.ir_count_left  <= left;
        sample_ch.ir_count_right <= right;
        sample_ch.tray_down_done <= down;
        sample_ch.tray_up_done   <= up;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predicted = advance_sequencer(left, right, down, up);
        expected_ticks.push_back(typed ? typed_res : predicted);
        items_sent++;
        gap = 0;
        if (calm_items > 0)
            calm_items--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                calm_items = $urandom_range(20, 60);
            else if (r < 60)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 98)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 50);
        end
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mostly counts at or a few tiles above the baselines, sometimes noise
    task automatic offer_random_tick();
        logic [CW-1:0] left;
        logic [CW-1:0] right;
        logic          down;
        logic          up;
        int unsigned   span;
        int unsigned   t;
        bit            noisy;
        noisy = ($urandom_range(0, 9) == 0)
                && !(seq_phase == PH_JUMP && seq_jump_sub == JS_WAIT_SINGLE);
        down  = 1'($urandom_range(0, 1));
        up    = 1'($urandom_range(0, 1));
        if (noisy)
        begin
            left  = ($urandom_range(0, 7) == 0) ? '1 : CW'($urandom);
            right = CW'($urandom);
            // keep deal baselines reachable
            if (seq_phase == PH_DEAL)
                up = 1'b0;
        end
        else
        begin
            span  = 3 + 32'(seq_steps);
            t     = 32'(seq_base_left) + $urandom_range(0, span);
            left  = (t > COUNT_TOP) ? '1 : CW'(t);
            t     = 32'(seq_base_right) + $urandom_range(0, span);
            right = (t > COUNT_TOP) ? '1 : CW'(t);
        end
        offer_sample(left, right, down, up, 1'b0, '0);
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_WIDTH-1:0] idx,
                               input logic [LIMIT_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_DEAL_ROUND_LIMIT)
            lim_deal = val;
        else
            lim_jump = val;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            if (errors < REPORT_CAP)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : cycle_guard
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: result with nothing expected, phase %0d sub %0d", $time,
                         result_ch.main_phase, result_ch.sub_phase);
                errors++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                check_field("init_pulse", 32'(want.init_pulse),
                            32'(result_ch.init_pulse));
                check_field("conveyor_cmd", 32'(want.conveyor_cmd),
                            32'(result_ch.conveyor_cmd));
                check_field("tray_cmd", 32'(want.tray_cmd), 32'(result_ch.tray_cmd));
                check_field("main_phase", 32'(want.main_phase),
                            32'(result_ch.main_phase));
                check_field("sub_phase", 32'(want.sub_phase), 32'(result_ch.sub_phase));
                check_field("rounds_done", 32'(want.rounds_done),
                            32'(result_ch.rounds_done));
                check_field("jump_count", 32'(want.jump_count),
                            32'(result_ch.jump_count));
            end
            results_seen <= results_seen + 1;
        end
    end

    initial
    begin : result_sink
        int stall_left;
        int calm_left;
        int r;
        bit held;
        stall_left = 0;
        calm_left  = 0;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // one long hold so the block backs up and stalls its input
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (calm_left > 0)
            begin
                result_ch.ready <= 1'b1;
                calm_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    calm_left = $urandom_range(20, 80);
                if (r < 65)
                    result_ch.ready <= 1'b1;
                else
                begin
                    result_ch.ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = REG_DEAL_ROUND_LIMIT;
        cfg_data                 = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.ir_count_left  = '0;
        sample_ch.ir_count_right = '0;
        sample_ch.tray_down_done = 1'b0;
        sample_ch.tray_up_done   = 1'b0;
        result_ch.ready          = 1'b0;

        // left, right, down, up, typed, then the hand-written result
        plan[0]  = {16'd0, 16'd0, 1'b0, 1'b0, 1'b1,
                    1'b1, CONV_NONE, TRAY_NONE, PH_DEAL, DS_WAIT_FIRST, 3'd0, 3'd0};
        plan[1]  = {16'd0, 16'd0, 1'b1, 1'b1, 1'b1,
                    1'b0, CONV_NONE, TRAY_NONE, PH_DEAL, DS_WAIT_FIRST, 3'd0, 3'd0};
        plan[2]  = {16'd65535, 16'd0, 1'b0, 1'b0, 1'b1,
                    1'b0, CONV_NONE, TRAY_NONE, PH_DEAL, DS_WAIT_FIRST, 3'd0, 3'd0};
        plan[3]  = {16'd0, 16'd65535, 1'b1, 1'b0, 1'b1,
                    1'b0, CONV_NONE, TRAY_NONE, PH_DEAL, DS_WAIT_FIRST, 3'd0, 3'd0};
        plan[4]  = {16'd1, 16'd1, 1'b0, 1'b0, 1'b1,
                    1'b0, CONV_STOP_BOTH, TRAY_LOWER, PH_DEAL, DS_TRAY_DOWN, 3'd0, 3'd0};
        plan[5]  = {16'd1, 16'd1, 1'b0, 1'b1, 1'b1,
                    1'b0, CONV_NONE, TRAY_NONE, PH_DEAL, DS_TRAY_DOWN, 3'd0, 3'd0};
        plan[6]  = {16'd2, 16'd2, 1'b1, 1'b0, 1'b1,
                    1'b0, CONV_START_BOTH, TRAY_NONE, PH_DEAL, DS_WAIT_SECOND, 3'd0, 3'd0};
        plan[7]  = {16'd1, 16'd65535, 1'b1, 1'b1, 1'b1,
                    1'b0, CONV_NONE, TRAY_NONE, PH_DEAL, DS_WAIT_SECOND, 3'd0, 3'd0};
        plan[8]  = {16'd65535, 16'd65535, 1'b1, 1'b1, 1'b1,
                    1'b0, CONV_STOP_BOTH, TRAY_RAISE, PH_DEAL, DS_TRAY_UP, 3'd0, 3'd0};
        plan[9]  = {16'd100, 16'd200, 1'b1, 1'b0, 1'b1,
                    1'b0, CONV_NONE, TRAY_NONE, PH_DEAL, DS_TRAY_UP, 3'd0, 3'd0};
        plan[10] = {16'd100, 16'd200, 1'b0, 1'b1, 1'b1,
                    1'b0, CONV_NONE, TRAY_NONE, PH_DEAL, DS_WAIT_FIRST, 3'd1, 3'd0};
        plan[11] = {16'd101, 16'd200, 1'b0, 1'b0, 1'b0, 17'd0};
        plan[12] = {16'd101, 16'd201, 1'b0, 1'b0, 1'b0, 17'd0};
        plan[13] = {16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 17'd0};
        plan[14] = {16'd102, 16'd202, 1'b0, 1'b0, 1'b0, 17'd0};
        plan[15] = {16'd40000, 16'd50000, 1'b0, 1'b1, 1'b0, 17'd0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
            offer_sample(plan[i].left, plan[i].right, plan[i].down, plan[i].up,
                         plan[i].typed, plan[i].res);

        settle();
        write_limit(REG_DEAL_ROUND_LIMIT, 3'd7);
        write_limit(REG_JUMP_STEP_LIMIT, 3'd7);
        cfg_we <= 1'b0;
        while (seq_rounds < 3'd4)
            offer_random_tick();

        // a zero deal limit ends the deal phase at the next round
        settle();
        write_limit(REG_DEAL_ROUND_LIMIT, 3'd0);
        cfg_we <= 1'b0;
        while (!(seq_phase == PH_JUMP && seq_steps >= 3'd5))
            offer_random_tick();

        settle();
        write_limit(REG_JUMP_STEP_LIMIT, 3'd1);
        cfg_we <= 1'b0;
        while (seq_phase != PH_NORMAL)
            offer_random_tick();

        settle();
        while (items_sent < ITEM_TOTAL)
            offer_random_tick();

        sample_ch.valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
design/tts_pkg.sv
design/tts_sample_if.sv
design/tts_result_if.sv
design/tts_cfg.sv
design/tts_step.sv
design/tile_tray_conveyor_sequencer.sv
tb/testbench.sv
